>>> sv/hrw_pkg.sv
// hrw_pkg: shared types, constants and helpers of the heater relay watchdog
// used by the interfaces, hrw_step and heater_relay_watchdog_core
package hrw_pkg;

  // field widths
  localparam int unsigned BEAT_W    = 16;
  localparam int unsigned RELAY_W   = 3;
  localparam int unsigned WATTS_W   = 12;
  localparam int unsigned TMO_W     = 24;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned CHANGE_W  = 25;
  localparam int unsigned BTIMER_W  = 17;
  localparam int unsigned CFG_W     = 24;

  // saturation limits and fixed codes
  localparam logic [CHANGE_W-1:0] CHANGE_MAX     = '1;
  localparam logic [BTIMER_W-1:0] BEAT_TIMER_MAX = '1;
  localparam logic [RELAY_W-1:0]  ALL_RELAYS     = 3'h7;
  localparam logic [RELAY_W-1:0]  NO_RELAYS      = 3'h0;

  // reset values of the configuration registers
  localparam logic [TMO_W-1:0]    TIMEOUT_RST = 24'd300000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd1000;

  // relay ratings in watts
  localparam logic [WATTS_W-1:0] WATTS_R0 = 12'd500;
  localparam logic [WATTS_W-1:0] WATTS_R1 = 12'd1000;
  localparam logic [WATTS_W-1:0] WATTS_R2 = 12'd2000;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_TIMEOUT     = 1'b0,
    REG_BEAT_PERIOD = 1'b1
  } hrw_reg_e;

  // configuration seen by the step logic
  typedef struct packed {
    logic [TMO_W-1:0]    timeout_ms;
    logic [PERIOD_W-1:0] beat_period_ms;
  } hrw_cfg_t;

  // one result item
  typedef struct packed {
    logic [RELAY_W-1:0] relay_drive;
    logic               error_lamp;
    logic [WATTS_W-1:0] power_watts;
    logic [BEAT_W-1:0]  beat_count;
    logic               beat_lamp;
    logic               mode_flag;
  } hrw_result_t;

  // watt sum of the active relays
  function automatic logic [WATTS_W-1:0] watts_of(input logic [RELAY_W-1:0] relays);
    logic [WATTS_W-1:0] w;
    w = '0;
    if (relays[0]) w = w + WATTS_R0;
    if (relays[1]) w = w + WATTS_R1;
    if (relays[2]) w = w + WATTS_R2;
    return w;
  endfunction

endpackage

>>> sv/hrw_if.sv
// hrw_req_if, hrw_res_if: valid/ready channels of the heater relay watchdog
// depends on hrw_pkg for field widths
interface hrw_req_if;
  logic                             valid;
  logic                             ready;
  logic                             override_on;
  logic [hrw_pkg::BEAT_W-1:0]       client_beat;
  logic [hrw_pkg::RELAY_W-1:0]      requested_relays;

  modport source (output valid, override_on, client_beat, requested_relays, input ready);
  modport sink   (input valid, override_on, client_beat, requested_relays, output ready);
endinterface

interface hrw_res_if;
  logic                             valid;
  logic                             ready;
  logic [hrw_pkg::RELAY_W-1:0]      relay_drive;
  logic                             error_lamp;
  logic [hrw_pkg::WATTS_W-1:0]      power_watts;
  logic [hrw_pkg::BEAT_W-1:0]       beat_count;
  logic                             beat_lamp;
  logic                             mode_flag;

  modport source (output valid, relay_drive, error_lamp, power_watts, beat_count,
                  beat_lamp, mode_flag, input ready);
  modport sink   (input valid, relay_drive, error_lamp, power_watts, beat_count,
                  beat_lamp, mode_flag, output ready);
endinterface

>>> sv/hrw_step.sv
// hrw_step: watchdog state and the per-tick update of relays, timers and beat
// depends on hrw_pkg
module hrw_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  hrw_pkg::hrw_cfg_t             cfg_i,
  input  logic                          override_on_i,
  input  logic [hrw_pkg::BEAT_W-1:0]    client_beat_i,
  input  logic [hrw_pkg::RELAY_W-1:0]   requested_relays_i,
  output hrw_pkg::hrw_result_t          result_o
);
  import hrw_pkg::*;

  logic                seen_q, seen_d;
  logic [BEAT_W-1:0]   stored_q, stored_d;
  logic [RELAY_W-1:0]  relay_q, relay_d;
  logic [CHANGE_W-1:0] chg_q, chg_d, chg_inc;
  logic [BTIMER_W-1:0] bt_q, bt_d, bt_inc;
  logic [BEAT_W-1:0]   own_q, own_d;
  logic                error;

  // saturating timers
  assign chg_inc = (chg_q != CHANGE_MAX) ? chg_q + 1'b1 : chg_q;
  assign bt_inc  = (bt_q != BEAT_TIMER_MAX) ? bt_q + 1'b1 : bt_q;

  // mode logic and beat counter
  always_comb begin
    seen_d   = seen_q;
    stored_d = stored_q;
    relay_d  = relay_q;
    chg_d    = chg_inc;
    bt_d     = bt_inc;
    own_d    = own_q;
    error    = 1'b0;
    if (override_on_i) begin
      error   = own_q[0];
      relay_d = ALL_RELAYS;
    end else if (!seen_q || (client_beat_i != stored_q)) begin
      seen_d   = 1'b1;
      stored_d = client_beat_i;
      chg_d    = '0;
      relay_d  = requested_relays_i;
    end else if (chg_inc > {1'b0, cfg_i.timeout_ms}) begin
      relay_d = NO_RELAYS;
      error   = 1'b1;
    end
    if (bt_inc > {1'b0, cfg_i.beat_period_ms}) begin
      bt_d  = '0;
      own_d = own_q + 1'b1;
    end
  end

  // result of this tick
  always_comb begin
    result_o.relay_drive = relay_d;
    result_o.error_lamp  = error;
    result_o.power_watts = watts_of(relay_d);
    result_o.beat_count  = own_d;
    result_o.beat_lamp   = own_d[0];
    result_o.mode_flag   = override_on_i;
  end

  // state registers, updated on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      stored_q <= '0;
      relay_q  <= '0;
      chg_q    <= '0;
      bt_q     <= '0;
      own_q    <= '0;
    end else if (en_i) begin
      seen_q   <= seen_d;
      stored_q <= stored_d;
      relay_q  <= relay_d;
      chg_q    <= chg_d;
      bt_q     <= bt_d;
      own_q    <= own_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a fresh heartbeat in auto mode restarts the timeout
  a_change_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !override_on_i && (client_beat_i != stored_q) |=> chg_q == '0)
    else $error("timeout timer not restarted on heartbeat change");
  // override drives every relay
  a_override_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && override_on_i |=> relay_q == ALL_RELAYS)
    else $error("override did not drive all relays");
  // beat counter moves by at most one per tick
  a_beat_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> (own_q == $past(own_q)) || (own_q == $past(own_q) + 1'b1))
    else $error("beat counter jumped");
`endif

endmodule

>>> sv/heater_relay_watchdog_core.sv
// heater_relay_watchdog_core: top level of the heater relay watchdog
// depends on hrw_pkg, hrw_req_if, hrw_res_if and hrw_step
//
// Usage: every request on req_i is one millisecond tick carrying the override
// switch, the client heartbeat and the requested relay bits. Each request
// gives exactly one result on res_o: relay drive, error lamp, watt sum, own
// beat counter, beat lamp and mode flag.
// Flow: a request's result is registered at its accepting edge, into the skid
// register if a result waits untaken. Throughput: one request per cycle while
// req_i.ready is high; the watchdog state is updated in a single pass at that edge.
// A two-entry output buffer (result register plus skid register) lets a new
// request in while one result waits; req_i.ready drops only when both are
// full, and comes back the cycle after res_o is taken.
// Configuration: cfg_we_i with cfg_idx_i 0 writes timeout_ms, 1 writes
// beat_period_ms; write only while idle.
// Reset (rst_ni low, asynchronous): timers, stored heartbeat, relays and the
// beat counter clear, registers return to 300000 and 1000, the output
// buffer empties.
module heater_relay_watchdog_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  hrw_pkg::hrw_reg_e           cfg_idx_i,
  input  logic [hrw_pkg::CFG_W-1:0]   cfg_wdata_i,
  hrw_req_if.sink                     req_i,
  hrw_res_if.source                   res_o
);
  import hrw_pkg::*;

  hrw_cfg_t    cfg_q;
  hrw_result_t step_res;
  hrw_result_t main_q, skid_q;
  logic        main_v_q, skid_v_q;
  logic        accept, take;

  assign req_i.ready = !skid_v_q;
  assign accept      = req_i.valid && req_i.ready;
  assign take        = main_v_q && res_o.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ms     <= TIMEOUT_RST;
      cfg_q.beat_period_ms <= PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TIMEOUT:     cfg_q.timeout_ms     <= cfg_wdata_i[TMO_W-1:0];
        REG_BEAT_PERIOD: cfg_q.beat_period_ms <= cfg_wdata_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // per-tick update
  hrw_step u_step (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (accept),
    .cfg_i              (cfg_q),
    .override_on_i      (req_i.override_on),
    .client_beat_i      (req_i.client_beat),
    .requested_relays_i (req_i.requested_relays),
    .result_o           (step_res)
  );

  // output buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (accept) begin
      if (main_v_q && !take) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end else if (take) begin
      main_v_q <= 1'b0;
    end
  end

  // output buffer payload
  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        main_q <= skid_q;
      end
    end else if (accept) begin
      if (main_v_q && !take) begin
        skid_q <= step_res;
      end else begin
        main_q <= step_res;
      end
    end
  end

  assign res_o.valid       = main_v_q;
  assign res_o.relay_drive = main_q.relay_drive;
  assign res_o.error_lamp  = main_q.error_lamp;
  assign res_o.power_watts = main_q.power_watts;
  assign res_o.beat_count  = main_q.beat_count;
  assign res_o.beat_lamp   = main_q.beat_lamp;
  assign res_o.mode_flag   = main_q.mode_flag;

`ifndef NO_ASSERTIONS
  // skid entry only holds a result behind a waiting one
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid register full while result register empty");
  // an accepted request always leaves a result
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> main_v_q)
    else $error("accepted request left no result");
  // a request accepted behind a stalled result goes to the skid register
  a_accept_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && main_v_q && !res_o.ready |=> skid_v_q)
    else $error("result lost behind a stalled output");
`endif

endmodule

>>> tb/tb_heater_relay_watchdog_core.sv
// tb_heater_relay_watchdog_core: self-checking bench for the heater relay watchdog core
// drives millisecond ticks over hrw_req_if, predicts relays, lamps and beat counter per tick
// depends on hrw_pkg, hrw_req_if, hrw_res_if and heater_relay_watchdog_core
`timescale 1ns / 1ps

module tb_heater_relay_watchdog_core;
  import hrw_pkg::*;

  // tick predictor and result scoreboard
  class relay_watchdog_scoreboard;
    logic [TMO_W-1:0]    timeout_ms;
    logic [PERIOD_W-1:0] beat_period_ms;
    bit                  heartbeat_seen;
    logic [BEAT_W-1:0]   stored_beat;
    logic [RELAY_W-1:0]  relay_cmd;
    logic [CHANGE_W-1:0] ms_since_change;
    logic [BTIMER_W-1:0] ms_since_beat;
    logic [BEAT_W-1:0]   own_beat;
    hrw_result_t         pending_results[$];
    int unsigned         n_checked;
    int unsigned         n_override;
    int unsigned         n_cut;
    int unsigned         n_errors;

    function new();
      timeout_ms      = TIMEOUT_RST;
      beat_period_ms  = PERIOD_RST;
      heartbeat_seen  = 1'b0;
      stored_beat     = '0;
      relay_cmd       = NO_RELAYS;
      ms_since_change = '0;
      ms_since_beat   = '0;
      own_beat        = '0;
    endfunction

    function void set_registers(logic [TMO_W-1:0] tmo, logic [PERIOD_W-1:0] period);
      timeout_ms     = tmo;
      beat_period_ms = period;
    endfunction

    // advance the watchdog by one accepted tick
    function void note_tick(logic ovr, logic [BEAT_W-1:0] beat, logic [RELAY_W-1:0] req);
      hrw_result_t res;
      logic        err;
      err = 1'b0;
      if (ms_since_change != CHANGE_MAX) ms_since_change = ms_since_change + 1'b1;
      if (ms_since_beat != BEAT_TIMER_MAX) ms_since_beat = ms_since_beat + 1'b1;

      if (ovr) begin
        err       = own_beat[0];
        relay_cmd = ALL_RELAYS;
        n_override++;
      end else if (!heartbeat_seen || beat != stored_beat) begin
        heartbeat_seen  = 1'b1;
        stored_beat     = beat;
        ms_since_change = '0;
        relay_cmd       = req;
      end else if (ms_since_change > {1'b0, timeout_ms}) begin
        relay_cmd = NO_RELAYS;
        err       = 1'b1;
        n_cut++;
      end

      if (ms_since_beat > {1'b0, beat_period_ms}) begin
        ms_since_beat = '0;
        own_beat      = own_beat + 1'b1;
      end

      res.relay_drive = relay_cmd;
      res.error_lamp  = err;
      res.power_watts = (relay_cmd[0] ? 12'd500 : 12'd0) + (relay_cmd[1] ? 12'd1000 : 12'd0)
                      + (relay_cmd[2] ? 12'd2000 : 12'd0);
      res.beat_count  = own_beat;
      res.beat_lamp   = own_beat[0];
      res.mode_flag   = ovr;
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (exp_val !== got_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
        n_errors++;
      end
    endfunction

    // compare one taken result with the oldest prediction
    function void check_result(hrw_result_t got);
      hrw_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: relay_drive %0d", got.relay_drive);
        n_errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      n_checked++;
      compare_field("relay_drive", 32'(exp_res.relay_drive), 32'(got.relay_drive));
      compare_field("error_lamp",  32'(exp_res.error_lamp),  32'(got.error_lamp));
      compare_field("power_watts", 32'(exp_res.power_watts), 32'(got.power_watts));
      compare_field("beat_count",  32'(exp_res.beat_count),  32'(got.beat_count));
      compare_field("beat_lamp",   32'(exp_res.beat_lamp),   32'(got.beat_lamp));
      compare_field("mode_flag",   32'(exp_res.mode_flag),   32'(got.mode_flag));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  hrw_reg_e            cfg_idx;
  logic [CFG_W-1:0]    cfg_wdata;

  hrw_req_if req_if ();
  hrw_res_if res_if ();

  heater_relay_watchdog_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  relay_watchdog_scoreboard sb = new();

  int unsigned       tx_idle_pct;
  int unsigned       rx_stall_pct;
  int unsigned       rx_hold_cycles;
  int unsigned       n_settings;
  logic [BEAT_W-1:0] last_beat;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: take results, stall at random or for a counted hold-off
  initial begin
    hrw_result_t got;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got.relay_drive = res_if.relay_drive;
        got.error_lamp  = res_if.error_lamp;
        got.power_watts = res_if.power_watts;
        got.beat_count  = res_if.beat_count;
        got.beat_lamp   = res_if.beat_lamp;
        got.mode_flag   = res_if.mode_flag;
        sb.check_result(got);
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // offer one tick request, with random gaps before it
  task automatic send_tick(logic ovr, logic [BEAT_W-1:0] beat, logic [RELAY_W-1:0] req);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid            <= 1'b1;
    req_if.override_on      <= ovr;
    req_if.client_beat      <= beat;
    req_if.requested_relays <= req;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_tick(ovr, beat, req);
    last_beat = beat;
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // write both registers, block idle
  task automatic write_settings(logic [TMO_W-1:0] tmo, logic [PERIOD_W-1:0] period);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk_i);
    cfg_idx   <= REG_BEAT_PERIOD;
    cfg_wdata <= {{(CFG_W-PERIOD_W){1'b0}}, period};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_registers(tmo, period);
    n_settings++;
  endtask

  // mostly heartbeat runs with occasional changes, some override and noise
  task automatic send_random_ticks(int unsigned count);
    logic              ovr;
    logic [BEAT_W-1:0] beat;
    for (int unsigned k = 0; k < count; k++) begin
      ovr  = ($urandom_range(99) < 12);
      beat = ($urandom_range(99) < 25) ? BEAT_W'($urandom) : last_beat;
      send_tick(ovr, beat, RELAY_W'($urandom_range(7)));
    end
  endtask

  // stimulus
  initial begin
    logic [TMO_W-1:0]    tmo_list[6];
    logic [PERIOD_W-1:0] period_list[6];
    rst_ni                  <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= REG_TIMEOUT;
    cfg_wdata               <= '0;
    req_if.valid            <= 1'b0;
    req_if.override_on      <= 1'b0;
    req_if.client_beat      <= '0;
    req_if.requested_relays <= '0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = 0;
    n_settings     = 0;
    last_beat      = '0;
    tmo_list    = '{24'd5, 24'd1, 24'hFFFFFF, 24'd0, 24'd12, TIMEOUT_RST};
    period_list = '{16'd3, 16'd1, 16'hFFFF, 16'd0, 16'd7, PERIOD_RST};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: first tick takes the request even though beat matches reset value
    send_tick(1'b0, 16'h0000, 3'd5);
    send_tick(1'b0, 16'h0000, 3'd2);
    send_tick(1'b0, 16'hFFFF, 3'd7);
    send_tick(1'b1, 16'h0F0F, 3'd0);
    send_tick(1'b0, 16'hFFFF, 3'd0);
    send_tick(1'b0, 16'h0001, 3'd0);

    // short timeout, beat counter advancing on every tick
    write_settings(24'd2, 16'd0);
    send_tick(1'b0, 16'hAAAA, 3'd3);
    repeat (4) send_tick(1'b0, 16'hAAAA, 3'd1);
    send_tick(1'b1, 16'hAAAA, 3'd0);
    send_tick(1'b1, 16'hAAAA, 3'd4);
    send_tick(1'b0, 16'hAAAA, 3'd7);
    send_tick(1'b0, 16'h5555, 3'd6);

    // zero timeout: any unchanged tick cuts the relays
    write_settings(24'd0, 16'd1);
    send_tick(1'b0, 16'h1234, 3'd1);
    send_tick(1'b0, 16'h1234, 3'd7);
    send_tick(1'b0, 16'h8000, 3'd2);

    // largest settings
    write_settings(24'hFFFFFF, 16'hFFFF);
    send_tick(1'b0, 16'h7FFF, 3'd4);
    send_tick(1'b0, 16'h7FFF, 3'd0);
    send_tick(1'b1, 16'h7FFF, 3'd7);

    // random phases over the idle patterns and settings
    for (int p = 0; p < 8; p++) begin
      write_settings(tmo_list[p % 6], period_list[p % 6]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      // long receiver hold-off while ticks keep coming, fills the output buffer
      if (p == 2) begin
        rx_hold_cycles = 40;
        send_random_ticks(12);
      end
      send_random_ticks(55);
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", sb.pending_results.size());
      sb.n_errors++;
    end
    $display("ticks checked %0d: %0d forced on, %0d watchdog cuts, %0d register settings",
             sb.n_checked, sb.n_override, sb.n_cut, n_settings);
    if (sb.n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
